@@ src/shp_pkg.sv @@
// shared types and constants for the 3x3 sharpening stream
// used by every module under src except shp_ram; no dependencies
package shp_pkg;

    // image geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 10;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int MIN_DIM    = 3;

    // pixel layout: red lowest, then green, blue, alpha
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 4 * CHAN_W;
    localparam int TAPS       = 9;

    // kernel selection codes
    localparam logic [1:0] KERNEL_NINE = 2'd1;
    localparam logic [1:0] KERNEL_FIVE = 2'd2;

    // register indexes of the write port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    typedef logic [PIX_W-1:0] t_pixel;

    // one window column: row above-above, row above, current row
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

endpackage

@@ src/shp_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module shp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/shp_cell.sv @@
// one column cell of the 3x3 window, passes its column on to its neighbour
// depends on shp_pkg
module shp_cell import shp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_column i_col,
    output t_column o_col
);

    t_column r_col;

    // take the neighbour's column on every window shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ src/shp_conv.sv @@
// one colour channel of the sharpening kernel, sum and clamp to 0..255
// depends on shp_pkg
module shp_conv import shp_pkg::*; (
    input  logic [1:0]                  i_mode,
    input  logic [TAPS-1:0][CHAN_W-1:0] i_taps,
    output logic [CHAN_W-1:0]           o_value
);

    logic        [CHAN_W+1:0] w_edges;
    logic        [CHAN_W+1:0] w_corners;
    logic signed [12:0]       w_centre;
    logic signed [12:0]       w_sum;

    // neighbour sums
    assign w_edges   = 10'(i_taps[1]) + 10'(i_taps[3]) + 10'(i_taps[5]) + 10'(i_taps[7]);
    assign w_corners = 10'(i_taps[0]) + 10'(i_taps[2]) + 10'(i_taps[6]) + 10'(i_taps[8]);
    assign w_centre  = signed'({5'd0, i_taps[4]});

    // kernel weights
    always_comb begin
        if (i_mode == KERNEL_NINE) begin
            w_sum = (w_centre <<< 3) + w_centre
                  - signed'({3'd0, w_edges}) - signed'({3'd0, w_corners});
        end else begin
            w_sum = (w_centre <<< 2) + w_centre
                  - signed'({2'd0, w_edges, 1'b0}) + signed'({3'd0, w_corners});
        end
    end

    // clamp
    always_comb begin
        if (w_sum < 0) begin
            o_value = '0;
        end else if (w_sum > 13'sd255) begin
            o_value = '1;
        end else begin
            o_value = w_sum[CHAN_W-1:0];
        end
    end

endmodule

@@ src/sharpen_3x3_rgb_stream.sv @@
// top level of the 3x3 sharpening filter for rgba pixel streams
// depends on shp_pkg, shp_ram, shp_cell and shp_conv
//
// channel   dir  handshake                      payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: red, green, blue, alpha
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: rgb, alpha, column, row; tlast
// cfg       in   i_cfg_we                        i_cfg_addr, i_cfg_wdata
//
// one pixel per clock unless the output stalls; path: stage 1, stage 2, output register
// the rate is set by the line store ram, one read and one write per pixel
// reset clears counters and valid flags, presets config; window, line stores are not cleared
// a stalled output holds its result while the earlier stages keep filling
module sharpen_3x3_rgb_stream import shp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // red[7:0] green[15:8] blue[23:16] alpha[31:24]
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // red, green, blue, alpha, column[41:32],
                                          // row[51:42], zero pad[55:52]
    output logic        o_m_axis_tlast,   // last interior pixel of the image
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [10:0] i_cfg_wdata
);

    // configuration
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [1:0]       r_mode;
    logic [DIM_W-1:0] w_width;
    logic [DIM_W-1:0] w_height;

    // position counters
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             w_wrap;
    logic [DIM_W-1:0] w_row_tmp;
    logic [CNT_W-1:0] w_cur_col;
    logic [CNT_W-1:0] w_cur_row;
    logic [DIM_W-1:0] w_col_inc;
    logic [DIM_W-1:0] w_row_inc;
    logic             w_produce;
    logic             w_last;

    // pipeline control
    logic w_out_free;
    logic w_s2_ready;
    logic w_s1_ready;
    logic w_s1_adv;
    logic w_accept;

    // stage 1: line store read in flight
    logic              r_s1_valid;
    t_pixel            r_s1_px;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_prod;
    logic [CNT_W-1:0]  r_s1_x;
    logic [CNT_W-1:0]  r_s1_y;
    logic              r_s1_last;

    // stage 2: window loaded
    logic              r_s2_valid;
    logic              r_s2_prod;
    logic [CNT_W-1:0]  r_s2_x;
    logic [CNT_W-1:0]  r_s2_y;
    logic              r_s2_last;

    // output register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic [CNT_W-1:0]  r_out_x;
    logic [CNT_W-1:0]  r_out_y;
    logic              r_out_last;

    logic [2*PIX_W-1:0] w_rd;
    t_column            w_new_col;
    t_column            w_cols [3];
    t_pixel             w_win  [TAPS];
    logic [PIX_W-1:0]   w_filt;

    // effective image size
    assign w_width  = (r_width  < DIM_W'(MIN_DIM))    ? DIM_W'(MIN_DIM)
                    : (r_width  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : r_width;
    assign w_height = (r_height < DIM_W'(MIN_DIM))    ? DIM_W'(MIN_DIM)
                    : (r_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_height;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_mode   <= KERNEL_NINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WIDTH:  r_width  <= i_cfg_wdata;
                REG_HEIGHT: r_height <= i_cfg_wdata;
                REG_KERNEL: r_mode   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // position of the arriving pixel, folded back if the size shrank
    assign w_wrap    = {1'b0, r_col} >= w_width;
    assign w_cur_col = w_wrap ? '0 : r_col;
    assign w_row_tmp = {1'b0, r_row} + DIM_W'(w_wrap);
    assign w_cur_row = (w_row_tmp >= w_height) ? '0 : w_row_tmp[CNT_W-1:0];

    // position of the following pixel
    assign w_col_inc = {1'b0, w_cur_col} + DIM_W'(1);
    assign w_row_inc = {1'b0, w_cur_row} + DIM_W'(1);
    always_comb begin
        if (w_col_inc >= w_width) begin
            n_col = '0;
            n_row = (w_row_inc >= w_height) ? '0 : w_row_inc[CNT_W-1:0];
        end else begin
            n_col = w_col_inc[CNT_W-1:0];
            n_row = w_cur_row;
        end
    end

    // interior pixel whose window completes with this pixel, under a filtering kernel code
    assign w_produce = (w_cur_col >= CNT_W'(2)) && (w_cur_row >= CNT_W'(2))
                    && (r_mode == KERNEL_NINE || r_mode == KERNEL_FIVE);
    assign w_last    = ({1'b0, w_cur_col} == w_width - DIM_W'(1))
                    && ({1'b0, w_cur_row} == w_height - DIM_W'(1));

    // handshake chain
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s2_ready      = !r_s2_valid || w_out_free;
    assign w_s1_ready      = !r_s1_valid || w_s2_ready;
    assign w_s1_adv        = r_s1_valid && w_s2_ready;
    assign o_s_axis_tready = w_s1_ready;
    assign w_accept        = i_s_axis_tvalid && w_s1_ready;

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores: upper half two rows up, lower half one row up
    shp_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata ({w_rd[PIX_W-1:0], r_s1_px}),
        .i_re    (w_accept),
        .i_raddr (w_cur_col[ADDR_W-1:0]),
        .o_rdata (w_rd)
    );

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px   <= i_s_axis_tdata;
            r_s1_addr <= w_cur_col[ADDR_W-1:0];
            r_s1_prod <= w_produce;
            r_s1_x    <= w_cur_col - CNT_W'(1);
            r_s1_y    <= w_cur_row - CNT_W'(1);
            r_s1_last <= w_last;
        end
    end

    // window cells, newest column enters cell 2
    assign w_new_col.top = w_rd[2*PIX_W-1:PIX_W];
    assign w_new_col.mid = w_rd[PIX_W-1:0];
    assign w_new_col.bot = r_s1_px;

    shp_cell u_cell2 (.i_clk(i_clk), .i_shift(w_s1_adv), .i_col(w_new_col), .o_col(w_cols[2]));
    shp_cell u_cell1 (.i_clk(i_clk), .i_shift(w_s1_adv), .i_col(w_cols[2]), .o_col(w_cols[1]));
    shp_cell u_cell0 (.i_clk(i_clk), .i_shift(w_s1_adv), .i_col(w_cols[1]), .o_col(w_cols[0]));

    // window taps in raster order
    generate
        for (genvar k = 0; k < 3; k++) begin : g_win
            assign w_win[k]     = w_cols[k].top;
            assign w_win[k + 3] = w_cols[k].mid;
            assign w_win[k + 6] = w_cols[k].bot;
        end
    endgenerate

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_prod <= r_s1_prod;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_last <= r_s1_last;
        end
    end

    // per channel kernels
    generate
        for (genvar ch = 0; ch < 3; ch++) begin : g_chan
            logic [TAPS-1:0][CHAN_W-1:0] w_taps;
            for (genvar k = 0; k < TAPS; k++) begin : g_tap
                assign w_taps[k] = w_win[k][ch*CHAN_W +: CHAN_W];
            end
            shp_conv u_conv (
                .i_mode  (r_mode),
                .i_taps  (w_taps),
                .o_value (w_filt[ch*CHAN_W +: CHAN_W])
            );
        end
    endgenerate

    // alpha of the centre pixel passes through
    assign w_filt[PIX_W-1 -: CHAN_W] = w_win[4][PIX_W-1 -: CHAN_W];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s2_valid && r_s2_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s2_valid) begin
            r_out_pix  <= w_filt;
            r_out_x    <= r_s2_x;
            r_out_y    <= r_s2_y;
            r_out_last <= r_s2_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_y, r_out_x, r_out_pix};
    assign o_m_axis_tlast  = r_out_last;

    // a held window must not move while its result cannot leave
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_out_valid && !i_m_axis_tready) |=> r_s2_valid)
        else $error("window stage dropped while output stalled");

    // results only come from interior pixels
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out_x != '0 && r_out_y != '0))
        else $error("result for a border pixel");

    // the last flag sits on the last interior column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> ({1'b0, r_out_x} + DIM_W'(2) == w_width))
        else $error("last flag away from the last interior column");

    // the column counter stays inside the row after each pixel
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ({1'b0, r_col} < w_width))
        else $error("column counter beyond image width");

endmodule

@@ dv/tb_sharpen_3x3_rgb_stream.sv @@
// self-checking testbench for the 3x3 sharpening filter on an rgba pixel stream
// drives pixels and register writes, predicts each interior result, checks it in order
// depends on shp_pkg and the sharpen_3x3_rgb_stream rtl under src
module tb_sharpen_3x3_rgb_stream import shp_pkg::*; ();

    // unused index of the write port
    localparam logic [1:0] REG_SPARE  = 2'd3;

    // kernel codes that select no filter
    localparam logic [1:0] MODE_OFF0 = 2'd0;
    localparam logic [1:0] MODE_OFF3 = 2'd3;

    localparam int SETTLE      = 8;        // pipeline is three deep, plus margin
    localparam int N_SMALL     = 800;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic       last;
        logic [9:0] row;
        logic [9:0] column;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_sharp_res;

    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} t_exp_kind;
    typedef enum logic {ROW_PIX, ROW_REG} t_row_op;

    typedef struct packed {
        t_row_op    op;
        logic [1:0] idx;
        logic [31:0] data;
        t_exp_kind  ek;
        t_sharp_res res;
    } t_step_row;

    localparam t_sharp_res NO_RESULT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [10:0] i_cfg_wdata;

    sharpen_3x3_rgb_stream dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // predictor state: two previous rows, 3x3 taps, next position, registers
    t_pixel      prev_row  [MAX_WIDTH];
    t_pixel      older_row [MAX_WIDTH];
    t_pixel      tap       [9];
    int unsigned next_col;
    int unsigned next_row;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [1:0]  cfg_mode;

    t_sharp_res  due_pixels [$];
    int unsigned n_errors;
    int unsigned n_pix;
    int unsigned n_results;
    int unsigned burst_left;
    int unsigned gap_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void flag(input string msg);
        if (n_errors < MAX_REPORTS)
            $display("%0t  %s", $time, msg);
        n_errors++;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
            flag($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    function automatic int unsigned eff_dim(input logic [10:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // one channel of the current window through the selected kernel, clamped
    function automatic logic [7:0] sharp_chan(input int sh);
        int ctr, edg, crn, acc;
        ctr = int'(tap[4][sh +: 8]);
        edg = int'(tap[1][sh +: 8]) + int'(tap[3][sh +: 8]) +
              int'(tap[5][sh +: 8]) + int'(tap[7][sh +: 8]);
        crn = int'(tap[0][sh +: 8]) + int'(tap[2][sh +: 8]) +
              int'(tap[6][sh +: 8]) + int'(tap[8][sh +: 8]);
        if (cfg_mode == KERNEL_NINE)
            acc = 9 * ctr - edg - crn;
        else
            acc = 5 * ctr - 2 * edg + crn;
        if (acc < 0) return 8'd0;
        if (acc > 255) return 8'd255;
        return 8'(acc);
    endfunction

    // advance the predictor by one pixel; made is set when an interior result is due
    function automatic void sharpen_step(input t_pixel px, output bit made,
                                         output t_sharp_res res);
        int unsigned w, h, c, r;
        t_pixel top, mid;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        // a shrink since the last pixel may leave the counters outside the image
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        c = next_col;
        r = next_row;

        top = older_row[c];
        mid = prev_row[c];
        older_row[c] = mid;
        prev_row[c]  = px;

        tap[0] = tap[1]; tap[1] = tap[2]; tap[2] = top;
        tap[3] = tap[4]; tap[4] = tap[5]; tap[5] = mid;
        tap[6] = tap[7]; tap[7] = tap[8]; tap[8] = px;

        made = 1'b0;
        res  = NO_RESULT;
        if (r >= 2 && c >= 2 && (cfg_mode == KERNEL_NINE || cfg_mode == KERNEL_FIVE)) begin
            res.red    = sharp_chan(0);
            res.green  = sharp_chan(8);
            res.blue   = sharp_chan(16);
            res.alpha  = tap[4][31:24];
            res.column = 10'(c - 1);
            res.row    = 10'(r - 1);
            res.last   = (c == w - 1) && (r == h - 1);
            made = 1'b1;
        end

        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly small sizes, now and then below the legal range or a little larger
    function automatic logic [10:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 11'($urandom_range(0, 2));
            1: return 11'($urandom_range(13, 40));
            default: return 11'($urandom_range(3, 12));
        endcase
    endfunction

    // kernel code in the low bits, junk above it
    function automatic logic [10:0] pick_mode();
        logic [1:0] m;
        case ($urandom_range(0, 9))
            0: m = MODE_OFF0;
            1: m = MODE_OFF3;
            2, 3, 4, 5: m = KERNEL_NINE;
            default: m = KERNEL_FIVE;
        endcase
        return {9'($urandom), m};
    endfunction

    function automatic t_step_row row_pix(input t_pixel px, input t_exp_kind ek,
                                          input t_sharp_res res);
        t_step_row s;
        s.op   = ROW_PIX;
        s.idx  = REG_WIDTH;
        s.data = px;
        s.ek   = ek;
        s.res  = res;
        return s;
    endfunction

    function automatic t_step_row row_reg(input logic [1:0] idx, input logic [10:0] val);
        t_step_row s;
        s.op   = ROW_REG;
        s.idx  = idx;
        s.data = 32'(val);
        s.ek   = EXP_NONE;
        s.res  = NO_RESULT;
        return s;
    endfunction

    // one pixel request, with the sender's burst and gap pattern around it
    task automatic send_pixel(input t_pixel px, input t_exp_kind ek, input t_sharp_res typed);
        bit made;
        t_sharp_res res;
        while (gap_left != 0) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
            gap_left--;
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = px;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sharpen_step(px, made, res);
        if (ek == EXP_TYPED)
            due_pixels.push_back(typed);
        else if (ek == EXP_MODEL && made)
            due_pixels.push_back(res);
        n_pix++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    // let every due result out, then let the pipeline drain
    task automatic wait_quiet();
        while (due_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        i_s_axis_tvalid = 1'b0;
        wait_quiet();
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = val;
            REG_HEIGHT: cfg_height = val;
            REG_KERNEL: cfg_mode   = val[1:0];
            default: ;
        endcase
    endtask

    // receiver stalls on a rotating mask that is redrawn at the end of each random-length phase
    initial begin
        logic [15:0] rdy_mask;
        int unsigned phase_left;
        i_m_axis_tready = 1'b0;
        rdy_mask   = '1;
        phase_left = 0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                phase_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: rdy_mask = '1;
                    1: rdy_mask = 16'($urandom) | 16'h0001;
                    2: rdy_mask = 16'h8000;
                    default: rdy_mask = (16'($urandom) & 16'($urandom)) | 16'h0100;
                endcase
            end
            i_m_axis_tready = rdy_mask[0];
            rdy_mask = {rdy_mask[0], rdy_mask[15:1]};
            phase_left--;
        end
    end

    // result checker: each accepted result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_sharp_res got, want;
        if (i_rst_n === 1'b1 && $isunknown(o_m_axis_tvalid))
            flag("output valid is unknown after reset");
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got.red    = o_m_axis_tdata[7:0];
            got.green  = o_m_axis_tdata[15:8];
            got.blue   = o_m_axis_tdata[23:16];
            got.alpha  = o_m_axis_tdata[31:24];
            got.column = o_m_axis_tdata[41:32];
            got.row    = o_m_axis_tdata[51:42];
            got.last   = o_m_axis_tlast;
            n_results++;
            if (due_pixels.size() == 0) begin
                flag($sformatf("result with nothing due: column %0d row %0d",
                               got.column, got.row));
            end else begin
                want = due_pixels.pop_front();
                check_field("red", 32'(want.red), 32'(got.red));
                check_field("green", 32'(want.green), 32'(got.green));
                check_field("blue", 32'(want.blue), 32'(got.blue));
                check_field("alpha", 32'(want.alpha), 32'(got.alpha));
                check_field("column", 32'(want.column), 32'(got.column));
                check_field("row", 32'(want.row), 32'(got.row));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    // watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, due_pixels.size());
        $display("sharpen_3x3_rgb_stream verification failed");
        $finish;
    end

    // stimulus
    initial begin
        t_step_row   directed [$];
        int unsigned ph, small_sent, k, interrupt_at, total, eff_w;
        logic [10:0] wv, hv, mv;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_WIDTH;
        i_cfg_wdata     = '0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) tap[i] = '0;
        next_col   = 0;
        next_row   = 0;
        cfg_width  = 11'd1024;
        cfg_height = 11'd1024;
        cfg_mode   = KERNEL_NINE;
        n_errors   = 0;
        n_pix      = 0;
        n_results  = 0;
        burst_left = 0;
        gap_left   = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed = '{
            // reset geometry and kernel; shrinking to 3x3 after three pixels wraps to row 1
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_reg(REG_WIDTH, 11'd3),
            row_reg(REG_HEIGHT, 11'd3),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_pix(32'hA500_01FF, EXP_NONE, NO_RESULT),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            row_pix(32'h0000_0000, EXP_NONE, NO_RESULT),
            // lone centre under the 9/-1 kernel: red saturates high, green times nine
            row_pix(32'h0000_0000, EXP_TYPED,
                    t_sharp_res'{red: 8'hFF, green: 8'd9, blue: 8'h00, alpha: 8'hA5,
                                 column: 10'd1, row: 10'd1, last: 1'b1}),
            // 5/-2/1 kernel: red on corners, green on edges, blue in the centre
            row_reg(REG_KERNEL, {9'd0, KERNEL_FIVE}),
            row_pix(32'h0000_00FF, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_FF00, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_00FF, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_FF00, EXP_MODEL, NO_RESULT),
            row_pix(32'h3CFF_0000, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_FF00, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_00FF, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_FF00, EXP_MODEL, NO_RESULT),
            row_pix(32'h0000_00FF, EXP_TYPED,
                    t_sharp_res'{red: 8'hFF, green: 8'h00, blue: 8'hFF, alpha: 8'h3C,
                                 column: 10'd1, row: 10'd1, last: 1'b1}),
            // unused kernel codes with junk upper bits: pixels stored, nothing produced
            row_reg(REG_KERNEL, {9'h1FF, MODE_OFF3}),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_reg(REG_KERNEL, {9'h1FF, MODE_OFF0}),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT),
            row_pix(32'hFFFF_FFFF, EXP_NONE, NO_RESULT)
        };
        foreach (directed[i]) begin
            if (directed[i].op == ROW_REG)
                write_reg(directed[i].idx, directed[i].data[10:0]);
            else
                send_pixel(directed[i].data, directed[i].ek, directed[i].res);
        end

        // random small images until the pixel budget is spent
        small_sent = 0;
        for (ph = 0; small_sent < N_SMALL; ph++) begin
            wv = pick_dim();
            hv = pick_dim();
            mv = pick_mode();
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_KERNEL, mv);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, 11'($urandom));

            eff_w = eff_dim(cfg_width, MAX_WIDTH);
            total = eff_w * eff_dim(cfg_height, MAX_HEIGHT);
            interrupt_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : 0;
            k = 0;
            // run until the counters come back to the top-left corner
            do begin
                send_pixel({rand_chan(), rand_chan(), rand_chan(), rand_chan()},
                           EXP_MODEL, NO_RESULT);
                k++;
                small_sent++;
                if (k == interrupt_at) begin
                    // mid-image change: width never grows, so no unwritten column is read
                    write_reg(REG_WIDTH, 11'($urandom_range(0, eff_w)));
                    write_reg(REG_HEIGHT, pick_dim());
                    write_reg(REG_KERNEL, pick_mode());
                end
            end while (next_col != 0 || next_row != 0);
        end

        i_s_axis_tvalid = 1'b0;
        wait_quiet();

        $display("covered %0d pixel requests: directed set, then %0d random small images",
                 n_pix, ph);
        $display("%0d sharpened results compared, with mid-image resizes and unused kernel codes",
                 n_results);
        if (n_errors == 0)
            $display("sharpen_3x3_rgb_stream verification clean");
        else
            $display("sharpen_3x3_rgb_stream verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/shp_pkg.sv
src/shp_ram.sv
src/shp_cell.sv
src/shp_conv.sv
src/sharpen_3x3_rgb_stream.sv
dv/tb_sharpen_3x3_rgb_stream.sv
